// ----- rtl/core/ifba_pkg.sv -----
// Package: widths, codes and entry layout of the flow accounting table.
`default_nettype none
package ifba_pkg;
    localparam int TableDepth = 1024;
    localparam int SlotW = $clog2(TableDepth);
    localparam int CountW = SlotW + 1;
    localparam int CfgW = 11;
    localparam int CfgIdxW = 1;
    localparam logic [CfgW-1:0] ResetCapacity = 11'd1024;
    localparam logic [CfgW-1:0] ResetMargin = 11'd256;

    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_MERGED  = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BADFAM  = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;
    localparam logic [2:0] ST_EMPTY   = 3'd6;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [CfgIdxW-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_MARGIN   = 1'd1;

    // key: family, proto, four address words, ports
    localparam int KeyW = 1 + 8 + 64 * 4 + 32;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  family;
        logic [7:0]  proto;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] length;
        logic [SlotW-1:0] slot;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [CountW-1:0] entry_count;
        logic        near_full;
        logic        rd_family;
        logic [7:0]  rd_proto;
        logic [63:0] rd_src_hi;
        logic [63:0] rd_src_lo;
        logic [63:0] rd_dst_hi;
        logic [63:0] rd_dst_lo;
        logic [15:0] rd_sport;
        logic [15:0] rd_dport;
        logic [63:0] rd_bytes;
    } out_item_t;
endpackage
`default_nettype wire

// ----- rtl/core/ifba_if.sv -----
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface ifba_in_if;
    import ifba_pkg::*;
    logic valid;
    logic ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ifba_out_if;
    import ifba_pkg::*;
    logic valid;
    logic ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ip_flow_byte_accounting_top.sv -----
// Top level of the flow byte accounting table.
//
// Usage
//   in  : ifba_in_if sink. One item per transfer: packet (kind 0), read slot
//         (kind 1) or clear (kind 2). Kind 3 answers slot empty.
//   out : ifba_out_if source. Exactly one result per input item.
//   cfg : cfg_we/cfg_idx/cfg_data write capacity (0) or save_margin (1),
//         only while idle.
// Timing
//   A packet walks the key memory linearly: one stored entry per cycle, read
//   through a registered memory port. A new or a rejected flow walks every
//   used entry, then S_CHECK and S_DONE; a hit ends the walk at its slot and
//   has its byte count read, saturated and written back in S_BYTES. Reads pass
//   S_RDWAIT, S_RDOUT, S_DONE, clears S_DONE. One item is in flight at a time.
// Output
//   The result sits in an output register; in.ready is low until it has
//   been taken, so a stalled receiver stalls the input.
// Reset
//   rst_n clears the entry count and restores capacity 1024, margin 256.
//   Memory contents are not cleared; only slots below the count are read.
`default_nettype none
module ip_flow_byte_accounting_top
    import ifba_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ifba_in_if.sink   in,
    ifba_out_if.source out,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_idx,
    input  wire logic [CfgW-1:0]    cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_CHECK, S_BYTES, S_RDWAIT, S_RDOUT, S_DONE
    } state_t;

    state_t state_reg;
    logic [CfgW-1:0] capacity_reg, margin_reg;
    logic [CountW-1:0] used_reg;
    logic [CountW-1:0] scan_reg;        // slot being addressed
    logic [SlotW-1:0] hit_reg;
    logic cmp_valid_reg;                // key data of scan_reg-1 on rdata
    in_item_t item_reg;
    logic [KeyW-1:0] key_reg;
    out_item_t res_reg;
    logic out_valid_reg;

    // memories
    logic key_we, bytes_we;
    logic [SlotW-1:0] key_waddr, bytes_waddr, key_raddr, bytes_raddr;
    logic [KeyW-1:0] key_rdata;
    logic [63:0] bytes_wdata, bytes_rdata;

    ifba_ram #(.Width(KeyW), .Depth(TableDepth)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_reg),
        .raddr(key_raddr), .rdata(key_rdata));
    ifba_ram #(.Width(64), .Depth(TableDepth)) u_bytes_ram (
        .clk(clk), .we(bytes_we), .waddr(bytes_waddr), .wdata(bytes_wdata),
        .raddr(bytes_raddr), .rdata(bytes_rdata));

    // key formed from the incoming item
    logic [KeyW-1:0] in_key;
    always_comb
    begin
        logic v4;
        logic tu;
        v4 = (in.data.family == 2'd0);
        tu = (in.data.proto == PROTO_TCP) || (in.data.proto == PROTO_UDP);
        in_key = {in.data.family[0], in.data.proto,
                  v4 ? 64'd0 : in.data.src_hi,
                  v4 ? {32'd0, in.data.src_lo[31:0]} : in.data.src_lo,
                  v4 ? 64'd0 : in.data.dst_hi,
                  v4 ? {32'd0, in.data.dst_lo[31:0]} : in.data.dst_lo,
                  tu ? {in.data.sport, in.data.dport} : 32'd0};
    end

    logic [CountW-1:0] eff_cap;
    assign eff_cap = (capacity_reg > CfgW'(TableDepth)) ? CountW'(TableDepth)
                                                        : CountW'(capacity_reg);

    function automatic logic near_f(input logic [CountW-1:0] c,
                                    input logic [CfgW-1:0] m,
                                    input logic [CountW-1:0] cap);
        return ({1'b0, c} + {1'b0, CountW'(m)}) >= {1'b0, cap};
    endfunction

    logic accept;
    assign accept = in.valid && in.ready;
    assign in.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out.valid = out_valid_reg;
    assign out.data = res_reg;

    logic [CountW-1:0] cmp_slot;
    assign cmp_slot = scan_reg - CountW'(1);
    logic match;
    assign match = cmp_valid_reg && (key_rdata == key_reg);

    // bytes memory follows the compared slot during the walk, so the hit's
    // count is on rdata in S_BYTES
    assign key_raddr = (state_reg == S_IDLE)   ? in.data.slot
                     : (state_reg == S_RDWAIT) ? item_reg.slot
                     : scan_reg[SlotW-1:0];
    assign bytes_raddr = (state_reg == S_IDLE)   ? in.data.slot
                       : (state_reg == S_RDWAIT) ? item_reg.slot
                       : (state_reg == S_SCAN)   ? cmp_slot[SlotW-1:0]
                       : hit_reg;
    assign key_waddr = used_reg[SlotW-1:0];
    assign key_we = (state_reg == S_CHECK) && !match && (used_reg < eff_cap);

    logic [64:0] sum;
    assign sum = {1'b0, bytes_rdata} + {49'd0, item_reg.length};
    assign bytes_we = key_we || (state_reg == S_BYTES);
    assign bytes_waddr = (state_reg == S_BYTES) ? hit_reg : used_reg[SlotW-1:0];
    assign bytes_wdata = (state_reg == S_BYTES) ? (sum[64] ? '1 : sum[63:0])
                                                : {48'd0, item_reg.length};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            capacity_reg <= ResetCapacity;
            margin_reg <= ResetMargin;
            used_reg <= '0;
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == REG_CAPACITY) capacity_reg <= cfg_data;
                else margin_reg <= cfg_data;
            end
            if (out_valid_reg && out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= in.data;
                        key_reg <= in_key;
                        res_reg <= '0;
                        scan_reg <= '0;
                        cmp_valid_reg <= 1'b0;
                        priority case (in.data.kind)
                            KIND_PACKET:
                            begin
                                if (in.data.family[1])
                                begin
                                    res_reg.status <= ST_BADFAM;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            KIND_READ: state_reg <= S_RDWAIT;
                            KIND_CLEAR:
                            begin
                                used_reg <= '0;
                                res_reg.status <= ST_CLEARED;
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                res_reg.status <= ST_EMPTY;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // address scan_reg now; compare previous slot's data
                    if (match)
                    begin
                        hit_reg <= cmp_slot[SlotW-1:0];
                        cmp_valid_reg <= 1'b0;
                        state_reg <= S_BYTES;
                    end
                    else if (scan_reg >= used_reg)
                    begin
                        cmp_valid_reg <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        cmp_valid_reg <= 1'b1;
                        scan_reg <= scan_reg + CountW'(1);
                    end
                end
                S_CHECK:
                begin
                    if (used_reg < eff_cap)
                    begin
                        res_reg.status <= ST_NEW;
                        used_reg <= used_reg + CountW'(1);
                    end
                    else
                    begin
                        res_reg.status <= ST_FULL;
                    end
                    state_reg <= S_DONE;
                end
                S_BYTES:
                begin
                    // bytes_rdata valid: addressed with the hit slot last cycle
                    res_reg.status <= ST_MERGED;
                    state_reg <= S_DONE;
                end
                S_RDWAIT:
                begin
                    state_reg <= S_RDOUT;
                end
                S_RDOUT:
                begin
                    if (CountW'(item_reg.slot) < used_reg)
                    begin
                        res_reg.status <= ST_READ;
                        {res_reg.rd_family, res_reg.rd_proto, res_reg.rd_src_hi,
                         res_reg.rd_src_lo, res_reg.rd_dst_hi, res_reg.rd_dst_lo,
                         res_reg.rd_sport, res_reg.rd_dport} <= key_rdata;
                        res_reg.rd_bytes <= bytes_rdata;
                    end
                    else
                    begin
                        res_reg.status <= ST_EMPTY;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    res_reg.entry_count <= used_reg;
                    res_reg.near_full <= near_f(used_reg, margin_reg, eff_cap);
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in.ready)
        else $error("input taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CountW'(TableDepth))
        else $error("entry count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        key_we |-> used_reg < eff_cap)
        else $error("append beyond capacity");
endmodule
`default_nettype wire

// ----- rtl/core/ifba_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module ifba_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- dv/ifba_checker.sv -----
// Checker: predicts every result of the flow table and compares transfers.
`timescale 1ns / 100ps
`default_nettype none
module ifba_checker
    import ifba_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire in_item_t           in_data,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire out_item_t          out_data,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_idx,
    input  wire logic [CfgW-1:0]    cfg_data,
    output int                      fail_count,
    output int                      pending,
    output int                      result_count
);
    typedef struct {
        logic        fam;
        logic [7:0]  proto;
        logic [63:0] shi, slo, dhi, dlo;
        logic [31:0] ports;
        logic [63:0] bytes;
    } flow_t;

    flow_t flow_tbl [TableDepth];
    int unsigned flows_used;
    int unsigned cap_reg, margin_reg;
    out_item_t result_q [$];

    function automatic int unsigned eff_cap();
        return (cap_reg > TableDepth) ? TableDepth : cap_reg;
    endfunction

    function automatic out_item_t account(in_item_t it);
        out_item_t r;
        flow_t f;
        logic [64:0] sum;
        int hit;
        r = '0;
        r.status = ST_EMPTY;
        if (it.kind == KIND_PACKET) begin
            if (it.family > 2'd1) r.status = ST_BADFAM;
            else begin
                f.fam = it.family[0];
                f.proto = it.proto;
                f.shi = it.family[0] ? it.src_hi : 64'd0;
                f.dhi = it.family[0] ? it.dst_hi : 64'd0;
                f.slo = it.family[0] ? it.src_lo : {32'd0, it.src_lo[31:0]};
                f.dlo = it.family[0] ? it.dst_lo : {32'd0, it.dst_lo[31:0]};
                f.ports = (it.proto == PROTO_TCP || it.proto == PROTO_UDP)
                          ? {it.sport, it.dport} : 32'd0;
                f.bytes = {48'd0, it.length};
                hit = -1;
                for (int i = 0; i < flows_used; i++)
                    if (hit < 0 && flow_tbl[i].fam == f.fam && flow_tbl[i].proto == f.proto
                        && flow_tbl[i].shi == f.shi && flow_tbl[i].slo == f.slo
                        && flow_tbl[i].dhi == f.dhi && flow_tbl[i].dlo == f.dlo
                        && flow_tbl[i].ports == f.ports)
                        hit = i;
                if (hit >= 0) begin
                    sum = {1'b0, flow_tbl[hit].bytes} + {49'd0, it.length};
                    flow_tbl[hit].bytes = sum[64] ? '1 : sum[63:0];
                    r.status = ST_MERGED;
                end else if (flows_used < eff_cap()) begin
                    flow_tbl[flows_used] = f;
                    flows_used++;
                    r.status = ST_NEW;
                end else r.status = ST_FULL;
            end
        end else if (it.kind == KIND_READ) begin
            if (it.slot < flows_used) begin
                f = flow_tbl[it.slot];
                r.status = ST_READ;
                r.rd_family = f.fam;
                r.rd_proto = f.proto;
                r.rd_src_hi = f.shi;
                r.rd_src_lo = f.slo;
                r.rd_dst_hi = f.dhi;
                r.rd_dst_lo = f.dlo;
                r.rd_sport = f.ports[31:16];
                r.rd_dport = f.ports[15:0];
                r.rd_bytes = f.bytes;
            end
        end else if (it.kind == KIND_CLEAR) begin
            flows_used = 0;
            r.status = ST_CLEARED;
        end
        r.entry_count = flows_used[CountW-1:0];
        r.near_full = (flows_used + margin_reg >= eff_cap());
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending = result_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t w;
        if (!rst_n)
        begin
            flows_used = 0;
            cap_reg = 32'(ResetCapacity);
            margin_reg = 32'(ResetMargin);
            result_q.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == REG_CAPACITY) cap_reg = 32'(cfg_data);
                else margin_reg = 32'(cfg_data);
            end
            if (in_valid && in_ready) result_q.push_back(account(in_data));
            if (out_valid && out_ready)
            begin
                result_count++;
                if (result_q.size() == 0) report("unexpected result", 64'd0, 64'd0);
                else
                begin
                    w = result_q.pop_front();
                    if (out_data.status != w.status)
                        report("status", 64'(out_data.status), 64'(w.status));
                    if (out_data.entry_count != w.entry_count)
                        report("entry_count", 64'(out_data.entry_count),
                               64'(w.entry_count));
                    if (out_data.near_full != w.near_full)
                        report("near_full", 64'(out_data.near_full), 64'(w.near_full));
                    if (out_data.rd_family != w.rd_family)
                        report("rd_family", 64'(out_data.rd_family), 64'(w.rd_family));
                    if (out_data.rd_proto != w.rd_proto)
                        report("rd_proto", 64'(out_data.rd_proto), 64'(w.rd_proto));
                    if (out_data.rd_src_hi != w.rd_src_hi)
                        report("rd_src_hi", out_data.rd_src_hi, w.rd_src_hi);
                    if (out_data.rd_src_lo != w.rd_src_lo)
                        report("rd_src_lo", out_data.rd_src_lo, w.rd_src_lo);
                    if (out_data.rd_dst_hi != w.rd_dst_hi)
                        report("rd_dst_hi", out_data.rd_dst_hi, w.rd_dst_hi);
                    if (out_data.rd_dst_lo != w.rd_dst_lo)
                        report("rd_dst_lo", out_data.rd_dst_lo, w.rd_dst_lo);
                    if (out_data.rd_sport != w.rd_sport)
                        report("rd_sport", 64'(out_data.rd_sport), 64'(w.rd_sport));
                    if (out_data.rd_dport != w.rd_dport)
                        report("rd_dport", 64'(out_data.rd_dport), 64'(w.rd_dport));
                    if (out_data.rd_bytes != w.rd_bytes)
                        report("rd_bytes", out_data.rd_bytes, w.rd_bytes);
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench top: stimulus, idling, configuration phases and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import ifba_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx = '0;
    logic [CfgW-1:0] cfg_data = '0;
    int fail_count, pending, result_count;
    int cycle_cnt = 0;
    int items_sent = 0;
    bit hold_off = 1'b0;      // long receiver stall request
    bit hold_done = 1'b0;

    ifba_in_if  in_ch ();
    ifba_out_if out_ch ();

    ip_flow_byte_accounting_top dut (
        .clk(clk), .rst_n(rst_n), .in(in_ch.sink), .out(out_ch.source),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    ifba_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Watchdog. Worst case per item is a full walk of 1024 entries plus stalls.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 10000000)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: pattern stalls, stall-free stretches, and one long hold-off.
    initial
    begin
        int mode;
        @(posedge rst_n);
        forever
        begin
            if (hold_off && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 40))
            begin
                @(posedge clk);
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= (cycle_cnt % 3) != 0;
                    2: out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Flow pool keeps random traffic hitting existing entries.
    in_item_t flow_pool [$];

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Idle point: all results back, then extra idle cycles with nothing in flight.
    task automatic drain();
        @(posedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (1100) @(posedge clk);
    endtask

    // One transfer; valid stays high across back-to-back items.
    task automatic send(in_item_t it);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // Occasional random gap between sends, with valid low.
    task automatic maybe_gap();
        if ($urandom_range(0, 9) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    function automatic in_item_t rand_packet();
        in_item_t it;
        it = '0;
        it.kind = KIND_PACKET;
        it.family = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(2, 3))
                                                 : 2'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: it.proto = PROTO_TCP;
            1: it.proto = PROTO_UDP;
            default: it.proto = 8'($urandom);
        endcase
        it.src_hi = {$urandom, $urandom};
        it.src_lo = {$urandom, $urandom};
        it.dst_hi = {$urandom, $urandom};
        it.dst_lo = {$urandom, $urandom};
        it.sport = 16'($urandom);
        it.dport = 16'($urandom);
        it.length = 16'($urandom);
        it.slot = SlotW'($urandom);
        return it;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45 && flow_pool.size() > 0)
        begin
            // repeat a known flow, perturbing fields that are not part of the key
            it = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
            it.length = 16'($urandom);
            it.slot = SlotW'($urandom);
            if (it.family == 2'd0)
            begin
                it.src_hi = {$urandom, $urandom};
                it.src_lo[63:32] = $urandom;
            end
            if (it.proto != PROTO_TCP && it.proto != PROTO_UDP) it.sport = 16'($urandom);
        end
        else if (pick < 75)
        begin
            it = rand_packet();
            if (flow_pool.size() < 64) flow_pool.push_back(it);
        end
        else
        begin
            it = rand_packet();
            it.kind = (pick < 93) ? KIND_READ : (pick < 98) ? KIND_CLEAR : 2'd3;
            it.slot = SlotW'($urandom_range(0, 40));
            if ($urandom_range(0, 7) == 0) it.slot = SlotW'($urandom);
        end
        return it;
    endfunction

    initial
    begin
        in_item_t it;
        int phase_cap [4] = '{1024, 0, 1, 20};
        int phase_mar [4] = '{256, 1024, 0, 5};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: extremes, every kind, full and bad family.
        cfg_write(REG_CAPACITY, 11'd3);
        cfg_write(REG_MARGIN, 11'd1);
        it = '0;
        it.kind = KIND_READ;
        send(it);                              // read on empty table
        it = '1;
        it.kind = KIND_PACKET;
        it.family = 2'd1;
        it.proto = PROTO_TCP;
        send(it);                              // all-ones IPv6 TCP
        send(it);                              // merge, byte count grows
        it.length = 16'hffff;
        repeat (3) send(it);
        it.family = 2'd0;
        it.proto = 8'd1;                       // IPv4 ICMP: upper halves and ports dropped
        send(it);
        it.src_hi = '0;
        it.sport = '0;
        it.dport = 16'h1234;
        it.src_lo[63:32] = '0;
        send(it);                              // same key, merges
        it = '0;
        it.proto = PROTO_UDP;
        send(it);                              // third entry fills table
        it.sport = 16'd1;
        send(it);                              // full
        it.family = 2'd2;
        send(it);
        it.family = 2'd3;
        send(it);
        for (int s = 0; s < 4; s++)
        begin
            it = '0;
            it.kind = KIND_READ;
            it.slot = SlotW'(s);
            send(it);
        end
        it.slot = '1;
        send(it);
        it.kind = 2'd3;
        send(it);
        drain();
        cfg_write(REG_CAPACITY, 11'd1);        // below count: merges only
        it = '1;
        it.kind = KIND_PACKET;
        it.family = 2'd1;
        it.proto = PROTO_TCP;
        send(it);
        it.proto = PROTO_UDP;
        send(it);
        it = '0;
        it.kind = KIND_CLEAR;
        send(it);
        drain();

        // Capacity and margin beyond the table depth.
        cfg_write(REG_CAPACITY, 11'd2047);
        cfg_write(REG_MARGIN, 11'd2047);

        // Random phases across several settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 4)
            begin
                cfg_write(REG_CAPACITY, CfgW'(phase_cap[ph]));
                cfg_write(REG_MARGIN, CfgW'(phase_mar[ph]));
            end
            else
            begin
                cfg_write(REG_CAPACITY, CfgW'($urandom_range(1, 60)));
                cfg_write(REG_MARGIN, CfgW'($urandom_range(0, 60)));
            end
            flow_pool.delete();
            repeat (210)
            begin
                send(rand_item());
                maybe_gap();
                if (ph == 2 && !hold_off && items_sent > 400)
                    hold_off = 1'b1;           // receiver holds; sender keeps offering
            end
            // Sender pause until all results are back.
            drain();
            it = '0;
            it.kind = KIND_CLEAR;
            send(it);
            drain();
        end

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("sent %0d items, checked %0d results, six config phases", items_sent,
                 result_count);
        $display("covered packets, merges, full and bad family, reads, clears");
        if (fail_count == 0 && hold_done)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/ifba_pkg.sv
rtl/core/ifba_if.sv
rtl/core/ifba_ram.sv
rtl/core/ip_flow_byte_accounting_top.sv
dv/ifba_checker.sv
dv/tb.sv
